// ===== rtl/sscc_pkg.sv =====
// Package: constants and types shared by the segment/sphere collision checker.
package sscc_pkg;
  localparam int MaxObstaclesDef = 64;
  localparam int CoordBitsDef    = 20;
  localparam int RadiusBits      = 19;
  localparam int CountBits       = 7;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_CHECK = 1'b1
  } req_t;
endpackage

// ===== rtl/sscc_test_pipe.sv =====
// Pipelined segment/sphere test: one obstacle enters per cycle, hit flag after six stages.
module sscc_test_pipe
  import sscc_pkg::*;
#(
  parameter int CoordBits = CoordBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [CoordBits-1:0]   ax,
  input  logic signed [CoordBits-1:0]   ay,
  input  logic signed [CoordBits-1:0]   az,
  input  logic signed [CoordBits-1:0]   bx,
  input  logic signed [CoordBits-1:0]   by,
  input  logic signed [CoordBits-1:0]   bz,
  input  logic signed [CoordBits-1:0]   cx,
  input  logic signed [CoordBits-1:0]   cy,
  input  logic signed [CoordBits-1:0]   cz,
  input  logic [RadiusBits-1:0]         rad,
  input  logic [RadiusBits-1:0]         margin,
  output logic                          out_valid,
  output logic                          hit
);
  localparam int DW = CoordBits + 1;          // differences
  localparam int PW = 2 * DW;                 // one product
  localparam int SW = PW + 2;                 // sum of three
  localparam int RW = RadiusBits + 1;
  localparam int CW = SW + 1;                 // c = ff - r^2
  localparam int HW = (CW > SW + 1 ? CW : SW + 1) + 1;
  localparam int HALF = (SW + 1) / 2;         // split for wide products

  logic [5:0] vld;

  // stage 1: differences and enlarged radius
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] f1 [3];
  logic [RW-1:0] r1;
  // stage 2: products
  logic signed [PW-1:0] dd2 [3];
  logic signed [PW-1:0] fd2 [3];
  logic signed [PW-1:0] ff2 [3];
  logic [2*RW-1:0] rr2;
  // stage 3: sums
  logic signed [SW-1:0] a3, g3;
  logic signed [CW-1:0] c3;
  // stage 4: case selection, operands for a*c against g*g
  logic dec4, need4;
  logic [SW-1:0] am4, gm4, cm4;
  // stage 5: partial products
  logic [2*HALF-1:0] ac_ll, ac_lh, ac_hl, ac_hh, gg_ll, gg_lh, gg_hh;
  logic dec5, need5;
  // stage 6
  logic [4*HALF+1:0] ac_full, gg_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    d1[0] <= DW'(bx) - DW'(ax);
    d1[1] <= DW'(by) - DW'(ay);
    d1[2] <= DW'(bz) - DW'(az);
    f1[0] <= DW'(ax) - DW'(cx);
    f1[1] <= DW'(ay) - DW'(cy);
    f1[2] <= DW'(az) - DW'(cz);
    r1    <= RW'(rad) + RW'(margin);
    for (int k = 0; k < 3; k++) begin
      dd2[k] <= d1[k] * d1[k];
      fd2[k] <= f1[k] * d1[k];
      ff2[k] <= f1[k] * f1[k];
    end
    rr2 <= r1 * r1;
    a3 <= SW'(dd2[0]) + SW'(dd2[1]) + SW'(dd2[2]);
    g3 <= SW'(fd2[0]) + SW'(fd2[1]) + SW'(fd2[2]);
    c3 <= CW'(SW'(ff2[0]) + SW'(ff2[1]) + SW'(ff2[2])) - CW'($signed({1'b0, rr2}));
  end

  // quick cases; the general one compares a*c <= g*g with g < 0, 0 < -g < a, c > 0
  logic signed [HW-1:0] end_val;
  logic quick_dec, quick_hit;
  always_comb begin
    end_val   = HW'(a3) + (HW'(g3) <<< 1) + HW'(c3);
    quick_dec = 1'b1;
    quick_hit = 1'b0;
    priority if (a3 == '0) begin
      quick_hit = c3 < 0;
    end else if (g3 >= 0) begin
      quick_hit = c3 <= 0;
    end else if (-HW'(g3) >= HW'(a3)) begin
      quick_hit = end_val <= 0;
    end else if (c3 <= 0) begin
      quick_hit = 1'b1;
    end else begin
      quick_dec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dec4  <= quick_hit;
    need4 <= !quick_dec;
    am4   <= SW'(a3);
    gm4   <= SW'(-g3);
    cm4   <= SW'(c3);   // c < a*... fits: c <= ff < SW range when used
    ac_ll <= am4[HALF-1:0] * cm4[HALF-1:0];
    ac_lh <= am4[HALF-1:0] * (2*HALF)'(cm4[SW-1:HALF]);
    ac_hl <= (2*HALF)'(am4[SW-1:HALF]) * cm4[HALF-1:0];
    ac_hh <= (2*HALF)'(am4[SW-1:HALF]) * (2*HALF)'(cm4[SW-1:HALF]);
    gg_ll <= gm4[HALF-1:0] * gm4[HALF-1:0];
    gg_lh <= gm4[HALF-1:0] * (2*HALF)'(gm4[SW-1:HALF]);
    gg_hh <= (2*HALF)'(gm4[SW-1:HALF]) * (2*HALF)'(gm4[SW-1:HALF]);
    dec5  <= dec4;
    need5 <= need4;
  end

  always_comb begin
    ac_full = (4*HALF+2)'(ac_ll) + ((4*HALF+2)'(ac_lh) << HALF)
            + ((4*HALF+2)'(ac_hl) << HALF) + ((4*HALF+2)'(ac_hh) << (2*HALF));
    gg_full = (4*HALF+2)'(gg_ll) + ((4*HALF+2)'(gg_lh) << (HALF+1))
            + ((4*HALF+2)'(gg_hh) << (2*HALF));
  end

  always_ff @(posedge clk) begin
    hit <= need5 ? (ac_full <= gg_full) : dec5;
  end

  assign out_valid = vld[5];
endmodule

// ===== rtl/segment_sphere_collision_check_unit.sv =====
// Top level: obstacle table memory, check sequencer and result register.
// Add item: the result is presented once the drain count has run out after acceptance.
// Check item: one obstacle read per cycle from the table memory for each stored obstacle,
//   six-stage test pipeline behind it, then the drain count before the result.
// One item at a time; the next item is taken the cycle after the result is accepted.
// Synchronous reset clears the obstacle count, margin and control; table contents
//   are undefined until written and never read beyond the count.
module segment_sphere_collision_check_unit
  import sscc_pkg::*;
#(
  parameter int MaxObstacles = MaxObstaclesDef,
  parameter int CoordBits    = CoordBitsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [RadiusBits-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic signed [CoordBits-1:0] point_a_x,
  input  logic signed [CoordBits-1:0] point_a_y,
  input  logic signed [CoordBits-1:0] point_a_z,
  input  logic signed [CoordBits-1:0] point_b_x,
  input  logic signed [CoordBits-1:0] point_b_y,
  input  logic signed [CoordBits-1:0] point_b_z,
  input  logic [RadiusBits-1:0]       radius,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        collision,
  output logic                        status,
  output logic [CountBits-1:0]        obstacle_count
);
  localparam int AW = (MaxObstacles > 1) ? $clog2(MaxObstacles) : 1;
  localparam int NW = $clog2(MaxObstacles + 1);
  localparam int EW = 3 * CoordBits + RadiusBits;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_OUT} state_t;

  state_t state;
  logic [RadiusBits-1:0] margin;
  logic [NW-1:0] count, idx;
  logic req_check;
  logic signed [CoordBits-1:0] ax, ay, az, bx, by, bz;
  logic found;

  logic [EW-1:0] mem [MaxObstacles];
  logic [EW-1:0] rd_data;
  logic rd_en, rd_vld;

  logic pipe_vld, pipe_hit;

  // pipeline empty: nothing in flight in memory read or test stages
  logic [2:0] drain_cnt;
  logic drain_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  wire accept = in_valid && in_ready;
  wire full   = (count == NW'(MaxObstacles));
  assign rd_en = (state == S_SCAN) && (idx < count);

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_ADD && !full) begin
      mem[count[AW-1:0]] <= {point_a_x, point_a_y, point_a_z, radius};
    end
    if (rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  sscc_test_pipe #(.CoordBits(CoordBits)) u_test (
    .clk, .rst,
    .in_valid (rd_vld),
    .ax, .ay, .az, .bx, .by, .bz,
    .cx       (rd_data[EW-1 -: CoordBits]),
    .cy       (rd_data[EW-1-CoordBits -: CoordBits]),
    .cz       (rd_data[EW-1-2*CoordBits -: CoordBits]),
    .rad      (rd_data[RadiusBits-1:0]),
    .margin,
    .out_valid(pipe_vld),
    .hit      (pipe_hit)
  );

  always_ff @(posedge clk) begin
    if (rst || state != S_DRAIN) drain_cnt <= '0;
    else if (!drain_done) drain_cnt <= drain_cnt + 1'b1;
  end
  assign drain_done = (drain_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      margin <= '0;
      count <= '0;
      idx <= '0;
      rd_vld <= 1'b0;
      found <= 1'b0;
      collision <= 1'b0;
      status <= 1'b0;
      obstacle_count <= '0;
      req_check <= 1'b0;
    end else begin
      if (cfg_valid) margin <= cfg_data;
      rd_vld <= rd_en;
      if (accept) found <= 1'b0;
      else if (pipe_vld && pipe_hit) found <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ax <= point_a_x; ay <= point_a_y; az <= point_a_z;
            bx <= point_b_x; by <= point_b_y; bz <= point_b_z;
            req_check <= (req_type == REQ_CHECK);
            idx <= '0;
            if (req_type == REQ_ADD) begin
              status <= full;
              collision <= 1'b0;
              if (!full) count <= count + 1'b1;
              state <= S_DRAIN;
            end else begin
              status <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx < count) idx <= idx + 1'b1;
          else state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (drain_done) begin
            if (req_check) collision <= found || (pipe_vld && pipe_hit);
            obstacle_count <= CountBits'(count);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(MaxObstacles)) else $error("count overflow");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> ($past(count) == count || $past(state) == S_IDLE))
    else $error("count changed outside accept");
  a_no_read_beyond: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (idx < count)) else $error("read beyond count");
endmodule
